@@ hw/rtl/crt_pkg.sv @@
// shared types and constants of the chunk receive tracker
`timescale 1ns / 1ps
package crt_pkg;

	localparam int MAX_CHUNKS_DEF  = 1024;
	localparam int MAX_REQUEST_DEF = 16;
	localparam int RESULT_CAP      = 16;

	localparam int MODE_W = 2;
	localparam int IDX_W  = 10;
	localparam int LEN_W  = 26;
	localparam int CB_W   = 16;
	localparam int LAT_W  = 16;
	localparam int KIND_W = 3;
	localparam int TIME_W = 32;
	localparam int DIV_W  = LEN_W + 1;

	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HS    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CHUNK = 2'd2;

	localparam logic [KIND_W-1:0] KIND_HS_OK    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REQUEST  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FINAL    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FINISHED = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REJECT   = 3'd4;

	localparam logic [LAT_W-1:0] LAT_RESET = 16'd10;

	typedef struct packed {
		logic              load;
		logic              div_start;
		logic              set_rej;
		logic              open_sess;
		logic              clr_step;
		logic              wr_chunk;
		logic              rd_prefix;
		logic              adv_prefix;
		logic              tick_eval;
		logic              emit;
		logic [KIND_W-1:0] emit_kind;
		logic              set_final_time;
		logic              close_sess;
		logic              scan_init;
		logic              rd_scan;
		logic              scan_next;
		logic              scan_hit;
		logic              set_heard_later;
		logic              flush;
	} crt_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              cb_zero;
		logic              div_done;
		logic              div_over;
		logic              rej;
		logic              clr_last;
		logic              chunk_ok;
		logic              prefix_lt;
		logic              rdata;
		logic              final_f;
		logic              finish_f;
		logic              req_f;
		logic              scan_more;
		logic              listed_nz;
		logic              can_emit;
		logic              pend_v;
		logic              out_busy;
	} crt_sts_t;

endpackage

@@ hw/rtl/chunk_receive_tracker_nack_unit.sv @@
// top level of the chunk receive tracker with missing-chunk requests
// one transaction at a time; in_ready is high only while the controller is idle
// chunk: ignored when outside the open session, else marked in the bitmap ram and followed by a prefix walk
// tick: evaluates the final, finished and request conditions; builds a request list by scanning bitmap entries
// handshake: a division, then a clearing sweep of all MAX_CHUNKS bitmap entries; a reject cuts this short
// reset: asynchronous, session closed, time and marks zero, latency LAT_RESET; results wait for out
`timescale 1ns / 1ps
module chunk_receive_tracker_nack_unit #(
	parameter int MAX_CHUNKS  = crt_pkg::MAX_CHUNKS_DEF,
	parameter int MAX_REQUEST = crt_pkg::MAX_REQUEST_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [crt_pkg::MODE_W-1:0] mode,
	input  logic [crt_pkg::IDX_W-1:0]  chunk_number,
	input  logic [crt_pkg::LEN_W-1:0]  total_length,
	input  logic [crt_pkg::CB_W-1:0]   chunk_bytes,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [crt_pkg::LAT_W-1:0]  cfg_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [crt_pkg::KIND_W-1:0] kind,
	output logic [crt_pkg::IDX_W-1:0]  missing_index,
	output logic                       last_of_run
);
	import crt_pkg::*;

	crt_cmd_t cmd;
	crt_sts_t sts;

	assign cfg_ready = 1'b1;

	crt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	crt_dp #(.MAX_CHUNKS(MAX_CHUNKS), .MAX_REQUEST(MAX_REQUEST)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.chunk_number  (chunk_number),
		.total_length  (total_length),
		.chunk_bytes   (chunk_bytes),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.missing_index (missing_index),
		.last_of_run   (last_of_run)
	);

	// an accepted transaction always takes the controller out of idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// single-result transactions always close their run
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_HS_OK || kind == KIND_REJECT || kind == KIND_FINISHED)
		|-> last_of_run)
		else $error("single result without last_of_run");

	// only request entries carry an index
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_REQUEST |-> missing_index == '0)
		else $error("index on a non-request result");

	// a taken last request entry is not followed by a non-last request entry with the same index
	a_no_result_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && kind == KIND_REQUEST && last_of_run |=> !(out_valid && kind == KIND_REQUEST && !last_of_run && $stable(missing_index)))
		else $error("request list repeated an entry");
endmodule

@@ hw/rtl/crt_ram.sv @@
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module crt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ hw/rtl/crt_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module crt_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [crt_pkg::DIV_W-1:0] num,
	input  logic [crt_pkg::CB_W-1:0]  den,
	output logic                      done,
	output logic [crt_pkg::DIV_W-1:0] quo
);
	import crt_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic [CB_W-1:0]  rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CB_W:0]    sh;
	logic             ge;

	assign sh = {rem_q, quo_q[DIV_W-1]};
	assign ge = sh >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? CB_W'(sh - {1'b0, den}) : CB_W'(sh);
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

@@ hw/rtl/crt_dp.sv @@
// datapath: session registers, timers, bitmap ram, divider and result buffer
`timescale 1ns / 1ps
module crt_dp #(
	parameter int MAX_CHUNKS  = crt_pkg::MAX_CHUNKS_DEF,
	parameter int MAX_REQUEST = crt_pkg::MAX_REQUEST_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  crt_pkg::crt_cmd_t          cmd,
	output crt_pkg::crt_sts_t          sts,
	input  logic [crt_pkg::MODE_W-1:0] mode,
	input  logic [crt_pkg::IDX_W-1:0]  chunk_number,
	input  logic [crt_pkg::LEN_W-1:0]  total_length,
	input  logic [crt_pkg::CB_W-1:0]   chunk_bytes,
	input  logic                       cfg_we,
	input  logic [crt_pkg::LAT_W-1:0]  cfg_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [crt_pkg::KIND_W-1:0] kind,
	output logic [crt_pkg::IDX_W-1:0]  missing_index,
	output logic                       last_of_run
);
	import crt_pkg::*;

	localparam int AW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CW    = $clog2(MAX_CHUNKS + 1);
	localparam int XW    = (CW > IDX_W) ? CW : IDX_W;
	localparam int CAP   = (MAX_REQUEST < RESULT_CAP) ? MAX_REQUEST : RESULT_CAP;
	localparam int LCW   = $clog2(CAP + 1);
	localparam int L2_W  = LAT_W + 1;
	localparam int L4_W  = LAT_W + 2;
	localparam int L100_W = LAT_W + 7;

	// input item
	logic [MODE_W-1:0] mode_q;
	logic [IDX_W-1:0]  idx_q;
	logic [LEN_W-1:0]  len_q;
	logic [CB_W-1:0]   cb_q;

	// latency multiples, formed when the register is written
	logic [L2_W-1:0]   lat2_q;
	logic [L4_W-1:0]   lat4_q;
	logic [L100_W-1:0] lat100_q;

	logic [TIME_W-1:0] time_q, lfinal_q, lheard_q, dtime_q;
	logic              dvalid_q, open_q, rej_q;
	logic [CW-1:0]     total_q, prefix_q, i_q;
	logic [LCW-1:0]    listed_q;
	logic              final_f_q, finish_f_q, req_f_q;

	logic              pend_v_q;
	logic [KIND_W-1:0] pend_kind_q;
	logic [IDX_W-1:0]  pend_idx_q;
	logic              out_v_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_last_q;

	logic [DIV_W-1:0]  div_num, quo;
	logic              div_done;
	logic              all_in, final_c, finish_c, req_c;
	logic              can_emit, move_out;
	logic              ram_we, ram_wdata, ram_re, ram_rdata;
	logic [AW-1:0]     ram_waddr, ram_raddr;

	assign div_num = {1'b0, len_q} + DIV_W'(cb_q) - DIV_W'(1);

	crt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (cb_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign ram_we    = cmd.wr_chunk | cmd.clr_step;
	assign ram_wdata = cmd.wr_chunk;
	assign ram_waddr = cmd.wr_chunk ? AW'(idx_q) : AW'(i_q);
	assign ram_re    = cmd.rd_prefix | cmd.rd_scan;
	assign ram_raddr = cmd.rd_scan ? AW'(i_q) : AW'(prefix_q);

	crt_ram #(.WIDTH(1), .DEPTH(MAX_CHUNKS)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign all_in   = prefix_q == total_q;
	assign final_c  = open_q && all_in && ((time_q - lfinal_q) > TIME_W'(lat4_q));
	assign finish_c = open_q && dvalid_q && ((time_q - dtime_q) > TIME_W'(lat100_q));
	// silence measured as a signed difference so a future mark reads as negative
	assign req_c    = open_q && !finish_c &&
		($signed(time_q - lheard_q) > $signed(TIME_W'(lat100_q)));

	assign can_emit = !pend_v_q || !out_v_q;
	assign move_out = (cmd.emit && pend_v_q) || cmd.flush;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			idx_q  <= chunk_number;
			len_q  <= total_length;
			cb_q   <= chunk_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat2_q   <= L2_W'({LAT_RESET, 1'b0});
			lat4_q   <= L4_W'({LAT_RESET, 2'b0});
			lat100_q <= L100_W'(LAT_RESET) * L100_W'(100);
		end else if (cfg_we) begin
			lat2_q   <= {cfg_data, 1'b0};
			lat4_q   <= {cfg_data, 2'b0};
			lat100_q <= L100_W'(cfg_data) * L100_W'(100);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q     <= '0;
			lfinal_q   <= '0;
			lheard_q   <= '0;
			dtime_q    <= '0;
			dvalid_q   <= 1'b0;
			open_q     <= 1'b0;
			rej_q      <= 1'b0;
			total_q    <= '0;
			prefix_q   <= '0;
			i_q        <= '0;
			listed_q   <= '0;
			final_f_q  <= 1'b0;
			finish_f_q <= 1'b0;
			req_f_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				rej_q <= 1'b0;
				if (mode == MODE_TICK) begin
					time_q <= time_q + 1'b1;
				end else if (mode == MODE_HS || mode == MODE_CHUNK) begin
					lheard_q <= time_q;
				end
			end
			if (cmd.set_rej) begin
				rej_q <= 1'b1;
			end
			if (cmd.open_sess) begin
				total_q  <= CW'(quo);
				prefix_q <= '0;
				open_q   <= 1'b1;
				dvalid_q <= 1'b0;
				i_q      <= '0;
			end
			if (cmd.clr_step || cmd.scan_next) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.adv_prefix) begin
				prefix_q <= prefix_q + 1'b1;
			end
			if (cmd.tick_eval) begin
				final_f_q  <= final_c;
				finish_f_q <= finish_c;
				req_f_q    <= req_c;
				if (open_q && all_in && !dvalid_q) begin
					dvalid_q <= 1'b1;
					dtime_q  <= time_q;
				end
			end
			if (cmd.set_final_time) begin
				lfinal_q <= time_q;
			end
			if (cmd.close_sess) begin
				open_q <= 1'b0;
			end
			if (cmd.scan_init) begin
				i_q      <= prefix_q;
				listed_q <= '0;
			end
			if (cmd.scan_hit) begin
				listed_q <= listed_q + 1'b1;
			end
			if (cmd.set_heard_later) begin
				lheard_q <= time_q + TIME_W'(lat2_q);
			end
		end
	end

	// one result waits in a pending slot until we know whether it closes the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.emit) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if (move_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pend_kind_q <= cmd.emit_kind;
			pend_idx_q  <= (cmd.emit_kind == KIND_REQUEST) ? IDX_W'(i_q) : '0;
		end
		if (move_out) begin
			out_kind_q <= pend_kind_q;
			out_idx_q  <= pend_idx_q;
			out_last_q <= cmd.flush;
		end
	end

	assign out_valid     = out_v_q;
	assign kind          = out_kind_q;
	assign missing_index = out_idx_q;
	assign last_of_run   = out_last_q;

	assign sts.mode      = mode_q;
	assign sts.cb_zero   = cb_q == '0;
	assign sts.div_done  = div_done;
	assign sts.div_over  = quo > DIV_W'(MAX_CHUNKS);
	assign sts.rej       = rej_q;
	assign sts.clr_last  = i_q == CW'(MAX_CHUNKS - 1);
	assign sts.chunk_ok  = open_q && (XW'(idx_q) < XW'(total_q));
	assign sts.prefix_lt = prefix_q < total_q;
	assign sts.rdata     = ram_rdata;
	assign sts.final_f   = final_f_q;
	assign sts.finish_f  = finish_f_q;
	assign sts.req_f     = req_f_q;
	assign sts.scan_more = (i_q < total_q) && (listed_q < LCW'(CAP));
	assign sts.listed_nz = listed_q != '0;
	assign sts.can_emit  = can_emit;
	assign sts.pend_v    = pend_v_q;
	assign sts.out_busy  = out_v_q;
endmodule

@@ hw/rtl/crt_ctrl.sv @@
// controller state machine sequencing handshake, chunk and tick transactions
`timescale 1ns / 1ps
module crt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  crt_pkg::crt_sts_t sts,
	output crt_pkg::crt_cmd_t cmd
);
	import crt_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE       = 15'b000000000000001,
		S_DISP       = 15'b000000000000010,
		S_HS         = 15'b000000000000100,
		S_DIV        = 15'b000000000001000,
		S_CLR        = 15'b000000000010000,
		S_HS_EMIT    = 15'b000000000100000,
		S_CHUNK      = 15'b000000001000000,
		S_WALK_RD    = 15'b000000010000000,
		S_WALK_CHK   = 15'b000000100000000,
		S_TICK_EVAL  = 15'b000001000000000,
		S_TICK_FINAL = 15'b000010000000000,
		S_TICK_FIN   = 15'b000100000000000,
		S_SCAN_RD    = 15'b001000000000000,
		S_SCAN_CHK   = 15'b010000000000000,
		S_FLUSH      = 15'b100000000000000
	} crt_state_t;

	crt_state_t state_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

	always_comb begin
		cmd      = '0;
		nxt      = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					nxt      = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.mode)
					MODE_TICK:  nxt = S_TICK_EVAL;
					MODE_HS:    nxt = S_HS;
					MODE_CHUNK: nxt = S_CHUNK;
					default:    nxt = S_FLUSH;
				endcase
			end
			S_HS: begin
				if (sts.cb_zero) begin
					cmd.set_rej = 1'b1;
					nxt         = S_HS_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					nxt           = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					if (sts.div_over) begin
						cmd.set_rej = 1'b1;
						nxt         = S_HS_EMIT;
					end else begin
						cmd.open_sess = 1'b1;
						nxt           = S_CLR;
					end
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					nxt = S_HS_EMIT;
				end
			end
			S_HS_EMIT: begin
				if (sts.can_emit) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = sts.rej ? KIND_REJECT : KIND_HS_OK;
					nxt           = S_FLUSH;
				end
			end
			S_CHUNK: begin
				if (sts.chunk_ok) begin
					cmd.wr_chunk = 1'b1;
					nxt          = S_WALK_RD;
				end else begin
					nxt = S_IDLE;
				end
			end
			S_WALK_RD: begin
				if (sts.prefix_lt) begin
					cmd.rd_prefix = 1'b1;
					nxt           = S_WALK_CHK;
				end else begin
					nxt = S_IDLE;
				end
			end
			S_WALK_CHK: begin
				if (sts.rdata) begin
					cmd.adv_prefix = 1'b1;
					nxt            = S_WALK_RD;
				end else begin
					nxt = S_IDLE;
				end
			end
			S_TICK_EVAL: begin
				cmd.tick_eval = 1'b1;
				nxt           = S_TICK_FINAL;
			end
			S_TICK_FINAL: begin
				if (!sts.final_f) begin
					nxt = S_TICK_FIN;
				end else if (sts.can_emit) begin
					cmd.emit           = 1'b1;
					cmd.emit_kind      = KIND_FINAL;
					cmd.set_final_time = 1'b1;
					nxt                = S_TICK_FIN;
				end
			end
			S_TICK_FIN: begin
				if (sts.finish_f) begin
					if (sts.can_emit) begin
						cmd.emit       = 1'b1;
						cmd.emit_kind  = KIND_FINISHED;
						cmd.close_sess = 1'b1;
						nxt            = S_FLUSH;
					end
				end else if (sts.req_f) begin
					cmd.scan_init = 1'b1;
					nxt           = S_SCAN_RD;
				end else begin
					nxt = S_FLUSH;
				end
			end
			S_SCAN_RD: begin
				if (sts.scan_more) begin
					cmd.rd_scan = 1'b1;
					nxt         = S_SCAN_CHK;
				end else begin
					cmd.set_heard_later = sts.listed_nz;
					nxt                 = S_FLUSH;
				end
			end
			S_SCAN_CHK: begin
				if (sts.rdata) begin
					cmd.scan_next = 1'b1;
					nxt           = S_SCAN_RD;
				end else if (sts.can_emit) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_REQUEST;
					cmd.scan_next = 1'b1;
					cmd.scan_hit  = 1'b1;
					nxt           = S_SCAN_RD;
				end
			end
			S_FLUSH: begin
				if (!sts.pend_v) begin
					nxt = S_IDLE;
				end else if (!sts.out_busy) begin
					cmd.flush = 1'b1;
					nxt       = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end
endmodule
